FILE: design/lvf_pkg.sv
// ----------------------------------------------------------------------------
// lvf_pkg: shared types and constants of the lane type vote filter
// Widths, register indexes, reset values and the structs passed between
// the sequencer and the top level.
// ----------------------------------------------------------------------------
package lvf_pkg;

  // number of class codes that carry a score
  localparam int NUM_CLASSES = 16;
  localparam int CLS_W       = $clog2(NUM_CLASSES);

  // field widths
  localparam int CLASS_W    = 4;
  localparam int CONF_W     = 8;
  localparam int SCORE_W    = 16;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int WINDOW_MAX = 64;
  localparam logic [SCORE_W-1:0] SCORE_MAX     = '1;
  localparam logic [CLS_W-1:0]   CLASS_UNKNOWN = '0;

  // register reset values
  localparam logic [CNT_W-1:0]   THRESHOLD_RST = CNT_W'(3);
  localparam logic [SCORE_W-1:0] KEEP_RST      = SCORE_W'(256);
  localparam logic [CNT_W-1:0]   WINDOW_RST    = CNT_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SWITCH_THRESHOLD = 2'd0,
    CFG_KEEP_WEIGHT      = 2'd1,
    CFG_HISTORY_WINDOW   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0]   switch_threshold;
    logic [SCORE_W-1:0] keep_weight;
    logic [CNT_W-1:0]   history_window;
  } cfg_t;

  typedef struct packed {
    logic [CLASS_W-1:0] tracked_class;
    logic [CNT_W-1:0]   run_count;
    logic               switched;
  } res_t;

endpackage

FILE: design/lvf_if.sv
// ----------------------------------------------------------------------------
// lvf_in_if / lvf_out_if: valid/ready channels of the lane type vote filter
// One beat moves on a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface lvf_in_if import lvf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] detected_class;
  logic [CONF_W-1:0]  confidence;

  modport source (output valid, output detected_class, output confidence, input ready);
  modport sink   (input valid, input detected_class, input confidence, output ready);
endinterface

interface lvf_out_if import lvf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] tracked_class;
  logic [CNT_W-1:0]   run_count;
  logic               switched;

  modport source (output valid, output tracked_class, output run_count, output switched,
                  input ready);
  modport sink   (input valid, input tracked_class, input run_count, input switched,
                  output ready);
endinterface

FILE: design/lane_type_vote_filter_unit.sv
// ----------------------------------------------------------------------------
// lane_type_vote_filter_unit: lane class vote filter, top level
// Config registers, score RAM, vote sequencer and the result register.
// ----------------------------------------------------------------------------
// Each input beat carries a detected class and its confidence; one result
// beat comes back per input beat with the filtered class, the run count used
// for the switch decision and a switched flag. Confidence is added into a
// saturating 16-bit Q8.8 score per class; the tracked class is the present
// class with the highest score (lowest code on a tie) unless a run of equal,
// known detections reaches switch_threshold, which wipes all scores, seeds
// that class with keep_weight and forces it. Until its result is registered,
// an item goes through these steps: the accept cycle latches it and reads
// its score, ST_ACC writes the updated score, ST_SCAN has the single score
// comparator walk the RAM one class per cycle, then a drain state (ST_LAST)
// and a decision state (ST_DONE), which waits while the output register is
// full. in_ch.ready is high only while the sequencer is idle; a finished
// result sits in the output register so the next item can be taken while
// it waits. Config writes are taken any cycle but are meant for idle.
// ----------------------------------------------------------------------------
module lane_type_vote_filter_unit import lvf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  lvf_in_if.sink                in_ch,
  lvf_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t               cfg_r;
  logic               out_valid_r;
  res_t               out_res_r;

  logic               ram_we;
  logic [CLS_W-1:0]   ram_waddr;
  logic [SCORE_W-1:0] ram_wdata;
  logic [CLS_W-1:0]   ram_raddr;
  logic [SCORE_W-1:0] ram_rdata;
  logic               res_free;
  logic               res_fire;
  res_t               res;

  // config registers; index 3 is a hole and is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.switch_threshold <= THRESHOLD_RST;
      cfg_r.keep_weight      <= KEEP_RST;
      cfg_r.history_window   <= WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SWITCH_THRESHOLD: cfg_r.switch_threshold <= cfg_wdata[CNT_W-1:0];
        CFG_KEEP_WEIGHT:      cfg_r.keep_weight      <= cfg_wdata[SCORE_W-1:0];
        CFG_HISTORY_WINDOW:   cfg_r.history_window   <= cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lvf_score_ram #(
    .DEPTH (NUM_CLASSES),
    .WIDTH (SCORE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lvf_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_ch.valid),
    .item_ready (in_ch.ready),
    .item_class (in_ch.detected_class),
    .item_conf  (in_ch.confidence),
    .cfg        (cfg_r),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .res_free   (res_free),
    .res_fire   (res_fire),
    .res        (res)
  );

  // output register: free when empty or draining this cycle
  assign res_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_fire) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.tracked_class = out_res_r.tracked_class;
  assign out_ch.run_count     = out_res_r.run_count;
  assign out_ch.switched      = out_res_r.switched;

endmodule

FILE: design/lvf_score_ram.sv
// ----------------------------------------------------------------------------
// lvf_score_ram: single write, single read RAM with registered read data
// Holds the per-class confidence scores.
// ----------------------------------------------------------------------------
module lvf_score_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/lvf_core.sv
// ----------------------------------------------------------------------------
// lvf_core: vote sequencer with one shared score comparator
// Tracks the run length, accumulates confidence, scans the score RAM one
// class per cycle for the best present class and applies the class switch.
// ----------------------------------------------------------------------------
module lvf_core import lvf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // item side
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [CLASS_W-1:0] item_class,
  input  logic [CONF_W-1:0]  item_conf,
  input  cfg_t               cfg,
  // score RAM
  output logic               ram_we,
  output logic [CLS_W-1:0]   ram_waddr,
  output logic [SCORE_W-1:0] ram_wdata,
  output logic [CLS_W-1:0]   ram_raddr,
  input  logic [SCORE_W-1:0] ram_rdata,
  // result side
  input  logic               res_free,
  output logic               res_fire,
  output res_t               res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [CLS_W-1:0]     det_r, det_nxt;
  logic [CONF_W-1:0]    conf_r, conf_nxt;
  logic [CLS_W-1:0]     last_r, last_nxt;
  logic [CNT_W-1:0]     run_r, run_nxt;
  logic [CLS_W-1:0]     cur_r, cur_nxt;
  logic [NUM_CLASSES-1:0] pres_r, pres_nxt;
  logic [CLS_W-1:0]     idx_r, idx_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [CLS_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                 found_r, found_nxt;
  logic [CLS_W-1:0]     best_r, best_nxt;
  logic [SCORE_W-1:0]   best_score_r, best_score_nxt;

  logic [CLS_W-1:0]     in_cls;
  logic [CNT_W-1:0]     win;
  logic [CNT_W-1:0]     run_inc;
  logic [SCORE_W:0]     acc_sum;
  logic [CNT_W-1:0]     count;
  logic                 sw;

  // codes beyond the class range count as unknown
  assign in_cls = (32'(item_class) >= NUM_CLASSES) ? CLASS_UNKNOWN : CLS_W'(item_class);

  always_comb begin
    if (cfg.history_window == '0) begin
      win = CNT_W'(1);
    end else if (cfg.history_window > CNT_W'(WINDOW_MAX)) begin
      win = CNT_W'(WINDOW_MAX);
    end else begin
      win = cfg.history_window;
    end
  end

  assign item_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    det_nxt        = det_r;
    conf_nxt       = conf_r;
    last_nxt       = last_r;
    run_nxt        = run_r;
    cur_nxt        = cur_r;
    pres_nxt       = pres_r;
    idx_nxt        = idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_score_nxt = best_score_r;
    ram_we         = 1'b0;
    ram_waddr      = det_r;
    ram_wdata      = '0;
    ram_raddr      = idx_r;
    res_fire       = 1'b0;
    run_inc        = '0;
    acc_sum        = '0;
    count          = '0;
    sw             = 1'b0;
    res            = '0;

    // shared compare: one RAM word per cycle against the running best
    if (cmp_vld_r && pres_r[cmp_idx_r] && (!found_r || ram_rdata > best_score_r)) begin
      found_nxt      = 1'b1;
      best_nxt       = cmp_idx_r;
      best_score_nxt = ram_rdata;
    end

    unique case (state_r)
      ST_IDLE: begin
        ram_raddr = in_cls;
        if (item_valid) begin
          if (run_r != '0 && in_cls == last_r) begin
            run_inc = run_r + CNT_W'(1);
          end else begin
            run_inc = CNT_W'(1);
          end
          run_nxt   = (run_inc > win) ? win : run_inc;
          last_nxt  = in_cls;
          det_nxt   = in_cls;
          conf_nxt  = item_conf;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        acc_sum = (pres_r[det_r] ? {1'b0, ram_rdata} : '0) + (SCORE_W + 1)'(conf_r);
        ram_we          = 1'b1;
        ram_wdata       = acc_sum[SCORE_W] ? SCORE_MAX : acc_sum[SCORE_W-1:0];
        pres_nxt[det_r] = 1'b1;
        found_nxt       = 1'b0;
        best_nxt        = cur_r;
        best_score_nxt  = '0;
        idx_nxt         = '0;
        state_nxt       = ST_SCAN;
      end
      ST_SCAN: begin
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = idx_r;
        if (idx_r == CLS_W'(NUM_CLASSES - 1)) begin
          state_nxt = ST_LAST;
        end else begin
          idx_nxt = idx_r + CLS_W'(1);
        end
      end
      ST_LAST: begin
        cmp_vld_nxt = 1'b0;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        count = (det_r != cur_r) ? run_r : CNT_W'(1);
        sw    = (count >= cfg.switch_threshold) && (det_r != CLASS_UNKNOWN);
        if (res_free) begin
          if (sw) begin
            pres_nxt        = '0;
            pres_nxt[det_r] = 1'b1;
            ram_we          = 1'b1;
            ram_wdata       = cfg.keep_weight;
            cur_nxt         = det_r;
          end else begin
            cur_nxt = best_r;
          end
          res_fire          = 1'b1;
          res.tracked_class = CLASS_W'(cur_nxt);
          res.run_count     = count;
          res.switched      = sw;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_r       <= CLASS_UNKNOWN;
      run_r        <= '0;
      cur_r        <= CLASS_UNKNOWN;
      pres_r       <= '0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      last_r       <= last_nxt;
      run_r        <= run_nxt;
      cur_r        <= cur_nxt;
      pres_r       <= pres_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      found_r      <= found_nxt;
      idx_r        <= idx_nxt;
    end
    det_r        <= det_nxt;
    conf_r       <= conf_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    best_r       <= best_nxt;
    best_score_r <= best_score_nxt;
  end

endmodule

FILE: design/lvf_checker.sv
// ----------------------------------------------------------------------------
// lvf_checker: port-level checks of the lane type vote filter
// Watches handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module lvf_checker import lvf_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [CLASS_W-1:0] out_tracked_class,
  input logic [CNT_W-1:0]   out_run_count,
  input logic               out_switched
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a waiting result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // one item at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item while busy");

  // a forced switch never lands on the unknown class
  a_switch_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switched |-> out_tracked_class != '0)
    else $error("switched to unknown class");

  // run count stays within one and the window cap
  a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_count != '0 && out_run_count <= CNT_W'(WINDOW_MAX))
    else $error("run count out of range");

endmodule

bind lane_type_vote_filter_unit lvf_checker u_lvf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_tracked_class (out_ch.tracked_class),
  .out_run_count     (out_ch.run_count),
  .out_switched      (out_ch.switched)
);
